FILE: rtl/core/vlan_rx_untag_classify_assert.svh
// Assertion macros for the VLAN receive untag and classify block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef VLAN_RX_UNTAG_CLASSIFY_ASSERT_SVH
`define VLAN_RX_UNTAG_CLASSIFY_ASSERT_SVH

`ifndef SYNTHESIS
`define VRX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vrx assertion failed");
`define VRX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vrx assertion failed");
`else
`define VRX_ASSERT_IMP(lbl, ante, cons)
`define VRX_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/vrx_pkg.sv
// Shared types and constants for the VLAN receive untag and classify block.
// No dependencies.
package vrx_pkg;

    localparam int BYTE_W          = 8;
    localparam int HDR_LEN         = 16;
    localparam int HDR_IDX_W       = 4;
    localparam int TAG_POS         = 12;
    localparam int TAG_LEN         = 4;
    localparam logic [7:0] TPID_HI = 8'h81;
    localparam logic [7:0] TPID_LO = 8'h00;
    localparam int VID_W           = 12;
    localparam logic [VID_W-1:0] VID_UNTAGGED = 12'd1;
    localparam int ENTRY_W         = 13;
    localparam int SLOT_W          = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int USER_W          = 3;
    localparam int TABLE_SLOTS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_DROP,
        OP_BURST
    } t_op;

    typedef struct packed {
        t_op                             op;
        logic [HDR_LEN-1:0][BYTE_W-1:0]  hdr;
        logic                            last;
        logic [SLOT_W-1:0]               slot;
        logic                            is_tagged;
    } t_cmd;

endpackage

FILE: rtl/core/vlan_rx_untag_classify.sv
// VLAN receive untag and classify, top level: front end, command queue, back end.
// Depends on vrx_pkg, vrx_front, vrx_queue, vrx_back and the assertion header.
//
// Bytes of an Ethernet frame enter one per word. The first 16 are held; on the
// 16th the frame is classified: an 802.1Q tag (TPID 0x8100 at offset 12) gives
// the VLAN ID and is stripped, an untagged frame counts as VLAN 1. The lowest
// valid matching slot wins; header words (12 tagged, 16 untagged) then leave as
// a burst and later bytes pass through one per cycle if not stalled, tagged
// with the slot in tuser. Unmatched frames and frames under 16 bytes give a
// single drop word at their last byte. Past the header, one input word per
// cycle is taken while the output is drained. The burst holds the back end for
// 12 or 16 words; the input keeps moving until the QUEUE_DEPTH-entry command
// queue is full. Slot registers are sampled at classification and should be
// written while the block is idle. No clearing pass is needed after reset.
module vlan_rx_untag_classify #(
    parameter int TABLE_SLOTS = vrx_pkg::TABLE_SLOTS_DEF,
    parameter int QUEUE_DEPTH = vrx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vrx_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vrx_pkg::ENTRY_W-1:0]   i_cfg_data,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [vrx_pkg::BYTE_W-1:0]    i_s_tdata,   // [7:0] frame_byte
    input  logic                          i_s_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [vrx_pkg::BYTE_W-1:0]    o_m_tdata,   // [7:0] out_byte
    output logic                          o_m_tlast,
    output logic [vrx_pkg::USER_W-1:0]    o_m_tuser    // [1:0] out_slot, [2] out_dropped
);
    import vrx_pkg::*;

    logic  q_push_valid, q_push_ready;
    t_cmd  q_push_cmd;
    logic  q_pop_valid, q_pop_ready;
    t_cmd  q_pop_cmd;

    vrx_front #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .o_push_valid (q_push_valid),
        .o_push_cmd   (q_push_cmd),
        .i_push_ready (q_push_ready)
    );

    vrx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .i_push_cmd   (q_push_cmd),
        .o_push_ready (q_push_ready),
        .o_pop_valid  (q_pop_valid),
        .o_pop_cmd    (q_pop_cmd),
        .i_pop_ready  (q_pop_ready)
    );

    vrx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (q_pop_valid),
        .i_pop_cmd   (q_pop_cmd),
        .o_pop_ready (q_pop_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

`include "vlan_rx_untag_classify_assert.svh"

    `VRX_ASSERT_IMP(a_push_room, q_push_valid, q_push_ready)
    `VRX_ASSERT_IMP(a_pop_has_item, q_pop_ready, q_pop_valid)
    `VRX_ASSERT_NXT(a_head_held, q_pop_valid && !q_pop_ready, q_pop_valid)
    `VRX_ASSERT_IMP(a_drop_format, o_m_tvalid && o_m_tuser[USER_W-1],
                    o_m_tlast && (o_m_tuser[SLOT_W-1:0] == '0) && (o_m_tdata == '0))

endmodule

FILE: rtl/core/vrx_front.sv
// Front end: header capture, tag detection, slot lookup and command issue.
// Depends on vrx_pkg.
module vrx_front #(
    parameter int TABLE_SLOTS = vrx_pkg::TABLE_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [vrx_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vrx_pkg::ENTRY_W-1:0]  i_cfg_data,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [vrx_pkg::BYTE_W-1:0]   i_s_tdata,
    input  logic                         i_s_tlast,
    output logic                         o_push_valid,
    output vrx_pkg::t_cmd                o_push_cmd,
    input  logic                         i_push_ready
);
    import vrx_pkg::*;

    typedef enum logic [1:0] {
        MODE_BUFFER,
        MODE_FORWARD,
        MODE_DISCARD
    } t_mode;

    t_mode                     r_mode, n_mode;
    logic [HDR_IDX_W-1:0]      r_pos, n_pos;
    logic [SLOT_W-1:0]         r_route, n_route;
    logic [BYTE_W-1:0]         r_hdr [HDR_LEN-1];
    logic [ENTRY_W-1:0]        r_slot [TABLE_SLOTS];

    logic                      accept;
    logic                      is_tagged;
    logic [VID_W-1:0]          vid;
    logic                      hit;
    logic [SLOT_W-1:0]         hit_slot;
    t_cmd                      cmd;
    logic                      push;

    assign o_s_tready = i_push_ready;
    assign accept     = i_s_tvalid && i_push_ready;

    assign is_tagged = (r_hdr[TAG_POS] == TPID_HI) && (r_hdr[TAG_POS+1] == TPID_LO);
    assign vid       = is_tagged ? {r_hdr[TAG_POS+2][VID_W-BYTE_W-1:0], i_s_tdata}
                                 : VID_UNTAGGED;

    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (r_slot[i][ENTRY_W-1] && (r_slot[i][VID_W-1:0] == vid)) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_route = r_route;
        push    = 1'b0;
        for (int k = 0; k < HDR_LEN - 1; k++) begin
            cmd.hdr[k] = r_hdr[k];
        end
        cmd.hdr[HDR_LEN-1] = i_s_tdata;
        cmd.op        = OP_DROP;
        cmd.last      = i_s_tlast;
        cmd.slot      = r_route;
        cmd.is_tagged = is_tagged;
        if (accept) begin
            case (r_mode)
                MODE_FORWARD: begin
                    push       = 1'b1;
                    cmd.op     = OP_BYTE;
                    cmd.hdr[0] = i_s_tdata;
                    if (i_s_tlast) begin
                        n_mode = MODE_BUFFER;
                        n_pos  = '0;
                    end
                end
                MODE_DISCARD: begin
                    if (i_s_tlast) begin
                        push   = 1'b1;
                        n_mode = MODE_BUFFER;
                        n_pos  = '0;
                    end
                end
                default: begin
                    if (r_pos != HDR_IDX_W'(HDR_LEN - 1)) begin
                        n_pos = r_pos + 1'b1;
                        if (i_s_tlast) begin
                            push   = 1'b1;
                            n_mode = MODE_BUFFER;
                            n_pos  = '0;
                        end
                    end else if (!hit) begin
                        if (i_s_tlast) begin
                            push   = 1'b1;
                            n_mode = MODE_BUFFER;
                            n_pos  = '0;
                        end else begin
                            n_mode = MODE_DISCARD;
                        end
                    end else begin
                        push     = 1'b1;
                        cmd.op   = OP_BURST;
                        cmd.slot = hit_slot;
                        n_route  = hit_slot;
                        n_pos    = '0;
                        n_mode   = i_s_tlast ? MODE_BUFFER : MODE_FORWARD;
                    end
                end
            endcase
        end
    end

    assign o_push_valid = push;
    assign o_push_cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BUFFER;
            r_pos   <= '0;
            r_route <= '0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_slot[i] <= '0;
            end
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_route <= n_route;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(i))) begin
                    r_slot[i] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (r_mode != MODE_FORWARD) && (r_mode != MODE_DISCARD) &&
            (r_pos != HDR_IDX_W'(HDR_LEN - 1))) begin
            r_hdr[r_pos] <= i_s_tdata;
        end
    end

endmodule

FILE: rtl/core/vrx_queue.sv
// Command queue between front and back end.
// Depends on vrx_pkg.
module vrx_queue #(
    parameter int DEPTH = vrx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  vrx_pkg::t_cmd  i_push_cmd,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output vrx_pkg::t_cmd  o_pop_cmd,
    input  logic           i_pop_ready
);
    import vrx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              push, pop;

    assign o_push_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

FILE: rtl/core/vrx_back.sv
// Back end: expands queued commands into output words, header burst included.
// Depends on vrx_pkg.
module vrx_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_pop_valid,
    input  vrx_pkg::t_cmd               i_pop_cmd,
    output logic                        o_pop_ready,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [vrx_pkg::BYTE_W-1:0]  o_m_tdata,
    output logic                        o_m_tlast,
    output logic [vrx_pkg::USER_W-1:0]  o_m_tuser
);
    import vrx_pkg::*;

    logic                  r_ovalid;
    logic [BYTE_W-1:0]     r_obyte, n_obyte;
    logic                  r_olast, n_olast;
    logic [SLOT_W-1:0]     r_oslot, n_oslot;
    logic                  r_odrop, n_odrop;
    logic [HDR_IDX_W-1:0]  r_idx, n_idx;

    logic                  load;
    logic                  pop;
    logic                  burst_end;

    assign load      = i_pop_valid && (!r_ovalid || i_m_tready);
    assign burst_end = (r_idx == (i_pop_cmd.is_tagged ? HDR_IDX_W'(TAG_POS - 1)
                                                      : HDR_IDX_W'(HDR_LEN - 1)));

    always_comb begin
        n_obyte = i_pop_cmd.hdr[0];
        n_olast = i_pop_cmd.last;
        n_oslot = i_pop_cmd.slot;
        n_odrop = 1'b0;
        n_idx   = r_idx;
        pop     = 1'b0;
        if (load) begin
            case (i_pop_cmd.op)
                OP_BYTE: begin
                    pop = 1'b1;
                end
                OP_BURST: begin
                    n_obyte = i_pop_cmd.hdr[r_idx];
                    n_olast = i_pop_cmd.last && burst_end;
                    if (burst_end) begin
                        pop   = 1'b1;
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                default: begin
                    n_obyte = '0;
                    n_olast = 1'b1;
                    n_oslot = '0;
                    n_odrop = 1'b1;
                    pop     = 1'b1;
                end
            endcase
        end
    end

    assign o_pop_ready = pop;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_obyte;
    assign o_m_tlast   = r_olast;
    assign o_m_tuser   = {r_odrop, r_oslot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_obyte <= n_obyte;
            r_olast <= n_olast;
            r_oslot <= n_oslot;
            r_odrop <= n_odrop;
        end
    end

endmodule

FILE: test/tb_vlan_rx_untag_classify.sv
`timescale 1ns / 100ps
// Testbench for vlan_rx_untag_classify: frames are streamed in, checked word by word
// against a built-in untag and slot-routing predictor. Depends on vrx_pkg and the RTL.
module tb_vlan_rx_untag_classify;
    import vrx_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = HDR_LEN + 8;
    localparam int VALID_BIT   = ENTRY_W - 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOT0,
        REG_SLOT1,
        REG_SLOT2,
        REG_SLOT3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        M_HEADER,
        M_FORWARD,
        M_DISCARD
    } t_rx_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [SLOT_W-1:0] slot;
        logic              dropped;
    } t_out_word;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [ENTRY_W-1:0]   i_cfg_data = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [BYTE_W-1:0]    i_s_tdata  = '0;  // [7:0] frame_byte
    logic                 i_s_tlast  = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [BYTE_W-1:0]    o_m_tdata;        // [7:0] out_byte
    logic                 o_m_tlast;
    logic [USER_W-1:0]    o_m_tuser;        // [1:0] out_slot, [2] out_dropped

    // predictor state
    logic [ENTRY_W-1:0] slot_table [TABLE_SLOTS_DEF];
    logic [BYTE_W-1:0]  hdr_bytes [HDR_LEN];
    logic [4:0]         hdr_count;
    logic [SLOT_W-1:0]  rx_route;
    t_rx_mode           rx_mode;
    t_out_word          words_due [$];

    logic [BYTE_W-1:0]  frame_buf [$];
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 errors        = 0;
    int                 words_in      = 0;
    int                 words_checked = 0;
    int                 drops_seen    = 0;
    int                 frames_sent   = 0;
    int                 stall_cycles  = 0;

    vlan_rx_untag_classify dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        foreach (slot_table[r]) slot_table[r] = '0;
        foreach (hdr_bytes[k]) hdr_bytes[k] = '0;
        hdr_count = '0;
        rx_route  = '0;
        rx_mode   = M_HEADER;
    end

    function automatic void push_drop();
        words_due.push_back('{data: '0, last: 1'b1, slot: '0, dropped: 1'b1});
        hdr_count = '0;
        rx_mode   = M_HEADER;
    endfunction

    function automatic void untag_and_route(logic [BYTE_W-1:0] b, logic last);
        logic            is_tagged;
        logic [VID_W-1:0] vid;
        int              keep;
        int              hit;
        case (rx_mode)
            M_FORWARD: begin
                words_due.push_back('{data: b, last: last, slot: rx_route, dropped: 1'b0});
                if (last) begin
                    hdr_count = '0;
                    rx_mode   = M_HEADER;
                end
            end
            M_DISCARD: begin
                if (last) push_drop();
            end
            default: begin
                hdr_bytes[hdr_count[HDR_IDX_W-1:0]] = b;
                hdr_count = hdr_count + 5'd1;
                if (hdr_count < HDR_LEN) begin
                    if (last) push_drop();
                end else begin
                    is_tagged = hdr_bytes[TAG_POS] == TPID_HI &&
                                hdr_bytes[TAG_POS+1] == TPID_LO;
                    vid    = VID_UNTAGGED;
                    keep   = HDR_LEN;
                    hit    = -1;
                    if (is_tagged) begin
                        vid  = {hdr_bytes[TAG_POS+2][3:0], hdr_bytes[TAG_POS+3]};
                        keep = HDR_LEN - TAG_LEN;
                    end
                    for (int i = TABLE_SLOTS_DEF - 1; i >= 0; i--)
                        if (slot_table[i][VALID_BIT] && slot_table[i][VID_W-1:0] == vid)
                            hit = i;
                    if (hit < 0) begin
                        if (last) push_drop();
                        else rx_mode = M_DISCARD;
                    end else begin
                        rx_route = SLOT_W'(hit);
                        for (int k = 0; k < keep; k++)
                            words_due.push_back('{data: hdr_bytes[k],
                                                  last: last && k == keep - 1,
                                                  slot: rx_route, dropped: 1'b0});
                        if (last) begin
                            hdr_count = '0;
                            rx_mode   = M_HEADER;
                        end else begin
                            rx_mode = M_FORWARD;
                        end
                    end
                end
            end
        endcase
    endfunction

    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always begin
        logic      fire;
        t_out_word got;
        t_out_word want;
        @(posedge i_clk);
        fire = i_rst_n && o_m_tvalid && i_m_tready;
        got  = '{data: o_m_tdata, last: o_m_tlast, slot: o_m_tuser[SLOT_W-1:0],
                 dropped: o_m_tuser[SLOT_W]};
        @(negedge i_clk);
        if (fire) begin
            if (words_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, actual %h", $time, got);
            end else begin
                want = words_due.pop_front();
                words_checked++;
                if (got.dropped) drops_seen++;
                if (got.data !== want.data || got.last !== want.last ||
                    got.slot !== want.slot || got.dropped !== want.dropped) begin
                    errors++;
                    $display("%0t: word mismatch: expected data %h last %b slot %0d drop %b,",
                             $time, want.data, want.last, want.slot, want.dropped);
                    $display("%0t:   actual data %h last %b slot %0d drop %b",
                             $time, got.data, got.last, got.slot, got.dropped);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d words outstanding",
                     $time, STALL_LIMIT, words_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        untag_and_route(b, last);
        words_in++;
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained(input int settle);
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (words_due.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic load_slots(input logic [ENTRY_W-1:0] e0, input logic [ENTRY_W-1:0] e1,
                              input logic [ENTRY_W-1:0] e2, input logic [ENTRY_W-1:0] e3);
        logic [ENTRY_W-1:0] vals [TABLE_SLOTS_DEF];
        vals = '{e0, e1, e2, e3};
        hold_until_drained(SETTLE);
        for (int r = REG_SLOT0; r <= REG_SLOT3; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(r);
            i_cfg_data <= vals[r];
            slot_table[r] = vals[r];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic build_frame(input int len, input bit is_tagged,
                               input logic [VID_W-1:0] vid);
        frame_buf = {};
        repeat (len) frame_buf.push_back(BYTE_W'($urandom));
        if (is_tagged) begin
            if (len > TAG_POS)     frame_buf[TAG_POS]   = TPID_HI;
            if (len > TAG_POS + 1) frame_buf[TAG_POS+1] = TPID_LO;
            if (len > TAG_POS + 2) frame_buf[TAG_POS+2] = {4'($urandom), vid[11:8]};
            if (len > TAG_POS + 3) frame_buf[TAG_POS+3] = vid[7:0];
        end else if (len > TAG_POS + 1 && frame_buf[TAG_POS] == TPID_HI &&
                     frame_buf[TAG_POS+1] == TPID_LO) begin
            frame_buf[TAG_POS+1] = 8'h01;
        end
    endtask

    task automatic send_frame(input bit pauses);
        for (int k = 0; k < frame_buf.size(); k++) begin
            send_word(frame_buf[k], k == frame_buf.size() - 1);
            if (pauses && k != frame_buf.size() - 1 && $urandom_range(15) == 0)
                hold_until_drained(0);
        end
        frames_sent++;
    endtask

    task automatic test_empty_table();
        build_frame(HDR_LEN, 1'b0, VID_UNTAGGED);
        frame_buf[0] = 8'hFF;
        frame_buf[1] = 8'h00;
        send_frame(1'b0);
        build_frame(1, 1'b0, VID_UNTAGGED);
        send_frame(1'b0);
    endtask

    task automatic test_extreme_vids();
        load_slots(13'h1000, 13'h1FFF, 13'h1001, 13'h0FFF);
        build_frame(HDR_LEN, 1'b1, 12'hFFF);
        send_frame(1'b0);
        build_frame(HDR_LEN + 2, 1'b1, 12'h000);
        send_frame(1'b0);
        build_frame(HDR_LEN + 1, 1'b0, VID_UNTAGGED);
        send_frame(1'b0);
        build_frame(HDR_LEN, 1'b1, 12'h005);
        send_frame(1'b0);
    endtask

    task automatic test_lowest_slot();
        load_slots(13'h0005, 13'h1005, 13'h1005, 13'h1ABC);
        build_frame(HDR_LEN + 1, 1'b1, 12'h005);
        send_frame(1'b0);
        build_frame(HDR_LEN, 1'b1, 12'hABC);
        send_frame(1'b0);
    endtask

    task automatic test_tag_lookalike();
        build_frame(HDR_LEN + 1, 1'b1, 12'h005);
        frame_buf[TAG_POS+1] = 8'h01;
        send_frame(1'b0);
    endtask

    task automatic test_short_frames();
        build_frame(HDR_LEN - 1, 1'b1, 12'h005);
        send_frame(1'b0);
        build_frame(TAG_POS + 2, 1'b1, 12'h005);
        send_frame(1'b0);
    endtask

    function automatic logic [ENTRY_W-1:0] rand_entry();
        logic [VID_W-1:0] id;
        case ($urandom_range(3))
            0:       id = '0;
            1:       id = VID_UNTAGGED;
            2:       id = '1;
            default: id = VID_W'($urandom);
        endcase
        return {1'($urandom_range(3) != 0), id};
    endfunction

    task automatic run_random_phase(input int s_pct, input int r_pct, input int n_words);
        int               sent;
        int               len;
        int               pick;
        bit               is_tagged;
        logic [VID_W-1:0] vid;
        sent = 0;
        load_slots(rand_entry(), rand_entry(), rand_entry(), rand_entry());
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        while (sent < n_words) begin
            pick = $urandom_range(99);
            if (pick < 20)      len = $urandom_range(1, HDR_LEN - 1);
            else if (pick < 75) len = $urandom_range(HDR_LEN, HDR_LEN + 4);
            else                len = $urandom_range(HDR_LEN + 5, 2 * HDR_LEN);
            is_tagged = $urandom_range(99) < 65;
            if ($urandom_range(99) < 70)
                vid = slot_table[$urandom_range(TABLE_SLOTS_DEF - 1)][VID_W-1:0];
            else
                vid = VID_W'($urandom);
            build_frame(len, is_tagged, vid);
            send_frame(1'b1);
            sent += len;
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_pct = 6;
        recv_idle_pct = 78;
        test_empty_table();
        test_extreme_vids();
        test_lowest_slot();
        test_tag_lookalike();
        test_short_frames();
        run_random_phase(6, 78, 10);
        run_random_phase(78, 6, 10);
        run_random_phase(0, 0, 10);
        hold_until_drained(SETTLE + 8);
        $display("Sent %0d frames (%0d bytes) over three idle mixes and five slot tables;",
                 frames_sent, words_in);
        $display("checked %0d output words, %0d of them drop notices, %0d errors.",
                 words_checked, drops_seen, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: vlan_rx_untag_classify.f
+incdir+rtl/core
rtl/core/vrx_pkg.sv
rtl/core/vrx_front.sv
rtl/core/vrx_queue.sv
rtl/core/vrx_back.sv
rtl/core/vlan_rx_untag_classify.sv
test/tb_vlan_rx_untag_classify.sv
